>>> hdl/gregorian_date_difference_macros.svh
// Assertion macros shared by the date difference block.
// Each macro expects a clock named clk and an active low reset named arst_n in scope.
`ifndef GREGORIAN_DATE_DIFFERENCE_MACROS_SVH
`define GREGORIAN_DATE_DIFFERENCE_MACROS_SVH

`ifndef SYNTH

// Checked only while the block is out of reset.
`define GDD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("gdd assertion failed");

// Checked at every edge, reset included.
`define GDD_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("gdd assertion failed during or after reset");

`else

`define GDD_ASSERT(lbl, prop)
`define GDD_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> hdl/gdd_pkg.sv
`default_nettype none

package gdd_pkg;

	localparam int unsigned DayW     = 5;
	localparam int unsigned MonthW   = 4;
	localparam int unsigned YearW    = 14;
	localparam int unsigned DiffW    = 23;
	localparam int unsigned DayNumW  = 23;
	localparam int unsigned DefaultMaxYear = 9999;

	typedef struct packed {
		logic [DayW-1:0]   first_day;
		logic [MonthW-1:0] first_month;
		logic [YearW-1:0]  first_year;
		logic [DayW-1:0]   second_day;
		logic [MonthW-1:0] second_month;
		logic [YearW-1:0]  second_year;
		logic              inclusive;
	} date_req_t;

	typedef struct packed {
		logic signed [DiffW-1:0] day_difference;
		logic                    invalid_date;
	} date_rsp_t;

	// Length of a month; zero for a month code outside 1 to 12.
	function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] month,
			input logic leap);
		logic [DayW-1:0] len;
		case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in a common year ahead of the first of the month.
	function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] month);
		logic [8:0] days;
		case (month)
			4'd1:    days = 9'd0;
			4'd2:    days = 9'd31;
			4'd3:    days = 9'd59;
			4'd4:    days = 9'd90;
			4'd5:    days = 9'd120;
			4'd6:    days = 9'd151;
			4'd7:    days = 9'd181;
			4'd8:    days = 9'd212;
			4'd9:    days = 9'd243;
			4'd10:   days = 9'd273;
			4'd11:   days = 9'd304;
			4'd12:   days = 9'd334;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

	// floor(x / 25) for x below 4096, by reciprocal multiply.
	function automatic logic [7:0] div25(input logic [11:0] x);
		logic [22:0] prod;
		prod = 23'(x) * 23'd1311;
		return prod[22:15];
	endfunction

endpackage

`default_nettype wire

>>> hdl/gdd_req_if.sv
`default_nettype none

interface gdd_req_if;
	logic                valid;
	logic                ready;
	gdd_pkg::date_req_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/gdd_rsp_if.sv
`default_nettype none

interface gdd_rsp_if;
	logic                valid;
	logic                ready;
	gdd_pkg::date_rsp_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/gdd_day_number.sv
`default_nettype none

// Days since 0001-01-01 for one date, plus a range check of the date.
module gdd_day_number #(
	parameter int unsigned MAX_YEAR = gdd_pkg::DefaultMaxYear
) (
	input  wire logic [gdd_pkg::DayW-1:0]    day,
	input  wire logic [gdd_pkg::MonthW-1:0]  month,
	input  wire logic [gdd_pkg::YearW-1:0]   year,
	output logic      [gdd_pkg::DayNumW-1:0] day_num,
	output logic                             date_ok
);

	localparam logic [15:0] MaxYear = 16'(MAX_YEAR);

	logic [gdd_pkg::YearW-1:0] prev_year;
	logic [11:0]               prev_quarter;
	logic [7:0]                prev_cent;
	logic [11:0]               year_quarter;
	logic [7:0]                year_cent;
	logic [11:0]               year_rem25;
	logic                      div4;
	logic                      div100;
	logic                      div400;
	logic                      leap;
	logic [gdd_pkg::DayW-1:0]  mlen;
	logic                      year_ok;
	logic                      month_ok;
	logic                      day_ok;

	// Leap rule: a year divisible by 100 is a leap year only when divisible by 400.
	assign year_quarter = year[gdd_pkg::YearW-1:2];
	assign year_cent    = gdd_pkg::div25(year_quarter);
	assign year_rem25   = year_quarter - 12'(year_cent) * 12'd25;
	assign div4         = (year[1:0] == 2'b00);
	assign div100       = div4 && (year_rem25 == 12'd0);
	assign div400       = div100 && (year_cent[1:0] == 2'b00);
	assign leap         = div400 || (div4 && !div100);

	assign mlen     = gdd_pkg::month_length(month, leap);
	assign year_ok  = (year != '0) && ({2'b00, year} <= MaxYear);
	assign month_ok = (month >= 4'd1) && (month <= 4'd12);
	assign day_ok   = (day != '0) && (day <= mlen);
	assign date_ok  = year_ok && month_ok && day_ok;

	// Whole years before this one; garbage for year zero, which is flagged anyway.
	assign prev_year    = year - 14'd1;
	assign prev_quarter = prev_year[gdd_pkg::YearW-1:2];
	assign prev_cent    = gdd_pkg::div25(prev_quarter);

	always_comb begin
		day_num = 23'(prev_year) * 23'd365
			+ 23'(prev_quarter)
			- 23'(prev_cent)
			+ 23'(prev_cent[7:2])
			+ 23'(gdd_pkg::days_before_month(month))
			+ 23'((leap && (month > 4'd2)) ? 1'b1 : 1'b0)
			+ 23'(day)
			- 23'd1;
	end

endmodule

`default_nettype wire

>>> hdl/gregorian_date_difference.sv
// Gregorian date difference.
// The dates channel carries one word per request: two dates (day, month, year)
// and an inclusive flag. The result channel returns one word per request: the
// signed day count from the first date to the second, and invalid_date, which is
// set with a zero count when either date is out of range.
// An accepted request is held in the input register and then moved into the
// result register, from which the receiver takes it. One request is accepted
// every cycle while the receiver keeps up. Between the input register and the
// result register sit the range checks and day numbers of both dates, each with a
// multiply by 365 and two reciprocal multiplies for the century count.
// The result register holds its word while the receiver stalls. An empty input
// register still takes one more request then; once both registers are full,
// dates.ready follows result.ready in the same cycle.
// Reset clears both valid bits; no request is lost or repeated after reset is
// released, and no clearing time is needed.
`default_nettype none

`include "gregorian_date_difference_macros.svh"

module gregorian_date_difference #(
	parameter int unsigned MAX_YEAR = gdd_pkg::DefaultMaxYear
) (
	input wire logic clk,
	input wire logic arst_n,
	gdd_req_if.sink   dates,
	gdd_rsp_if.source result
);

	localparam logic signed [23:0] SatHigh = 24'sd4194303;
	localparam logic signed [23:0] SatLow  = -24'sd4194304;

	logic                        v_s1;
	gdd_pkg::date_req_t          req_s1;
	logic                        v_s2;
	gdd_pkg::date_rsp_t          rsp_s2;
	logic                        advance;

	logic [gdd_pkg::DayNumW-1:0] num_first;
	logic [gdd_pkg::DayNumW-1:0] num_second;
	logic                        ok_first;
	logic                        ok_second;
	logic signed [23:0]          diff;
	logic signed [23:0]          diff_adj;
	gdd_pkg::date_rsp_t          rsp_next;

	assign advance      = v_s1 && (!v_s2 || result.ready);
	assign dates.ready  = !v_s1 || advance;
	assign result.valid = v_s2;
	assign result.data  = rsp_s2;

	gdd_day_number #(.MAX_YEAR(MAX_YEAR)) u_first (
		.day     (req_s1.first_day),
		.month   (req_s1.first_month),
		.year    (req_s1.first_year),
		.day_num (num_first),
		.date_ok (ok_first)
	);

	gdd_day_number #(.MAX_YEAR(MAX_YEAR)) u_second (
		.day     (req_s1.second_day),
		.month   (req_s1.second_month),
		.year    (req_s1.second_year),
		.day_num (num_second),
		.date_ok (ok_second)
	);

	always_comb begin
		diff = $signed({1'b0, num_second}) - $signed({1'b0, num_first});
		diff_adj = diff;
		// Inclusive counting grows the magnitude; equal dates count as plus one.
		if (req_s1.inclusive) begin
			diff_adj = diff[23] ? (diff - 24'sd1) : (diff + 24'sd1);
		end
		if (!(ok_first && ok_second)) begin
			rsp_next.day_difference = '0;
			rsp_next.invalid_date   = 1'b1;
		end else begin
			rsp_next.invalid_date = 1'b0;
			if (diff_adj > SatHigh) begin
				rsp_next.day_difference = SatHigh[22:0];
			end else if (diff_adj < SatLow) begin
				rsp_next.day_difference = SatLow[22:0];
			end else begin
				rsp_next.day_difference = diff_adj[22:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (dates.ready) begin
				v_s1 <= dates.valid;
			end
			if (advance) begin
				v_s2 <= 1'b1;
			end else if (result.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dates.valid && dates.ready) begin
			req_s1 <= dates.data;
		end
		if (advance) begin
			rsp_s2 <= rsp_next;
		end
	end

	`GDD_ASSERT(a_invalid_zero, (v_s2 && rsp_s2.invalid_date) |-> (rsp_s2.day_difference == '0))
	`GDD_ASSERT(a_accept_loads, (dates.valid && dates.ready) |=> v_s1)
	`GDD_ASSERT(a_free_advance, (v_s1 && !v_s2) |=> v_s2)
	`GDD_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (!v_s1 && !v_s2))

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Holds every request in flight together with the day count it must produce.
class date_diff_scoreboard;
	typedef struct {
		gdd_pkg::date_req_t req;
		gdd_pkg::date_rsp_t rsp;
	} awaited_t;

	awaited_t awaited_q[$];
	int unsigned mismatch_count = 0;

	function bit leap_year(int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function int unsigned month_days(int unsigned m, int unsigned y);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap_year(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	function bit date_valid(int unsigned d, int unsigned m, int unsigned y);
		return (y >= 1) && (y <= gdd_pkg::DefaultMaxYear) && (m >= 1) && (m <= 12)
			&& (d >= 1) && (d <= month_days(m, y));
	endfunction

	// Days elapsed since the first of January of year one.
	function int serial_day(int unsigned d, int unsigned m, int unsigned y);
		int unsigned p;
		int unsigned n;
		p = y - 1;
		n = 365 * p + p / 4 - p / 100 + p / 400 + d - 1;
		for (int unsigned k = 1; k < m; k++)
			n += month_days(k, y);
		return int'(n);
	endfunction

	function gdd_pkg::date_rsp_t predict_day_count(gdd_pkg::date_req_t w);
		gdd_pkg::date_rsp_t r;
		int span;
		int top;
		top = (1 <<< (gdd_pkg::DiffW - 1)) - 1;
		r.day_difference = '0;
		r.invalid_date = 1'b0;
		if (!date_valid(w.first_day, w.first_month, w.first_year)
				|| !date_valid(w.second_day, w.second_month, w.second_year)) begin
			r.invalid_date = 1'b1;
		end else begin
			span = serial_day(w.second_day, w.second_month, w.second_year)
				- serial_day(w.first_day, w.first_month, w.first_year);
			// Counting both end dates widens the span away from zero.
			if (w.inclusive)
				span += (span < 0) ? -1 : 1;
			if (span > top)
				span = top;
			if (span < -top - 1)
				span = -top - 1;
			r.day_difference = span[gdd_pkg::DiffW-1:0];
		end
		return r;
	endfunction

	function string request_text(gdd_pkg::date_req_t w);
		return $sformatf("%0d/%0d/%0d to %0d/%0d/%0d inclusive %0b",
			w.first_day, w.first_month, w.first_year,
			w.second_day, w.second_month, w.second_year, w.inclusive);
	endfunction

	task report_mismatch(string what);
		$display("ERROR: %s", what);
		mismatch_count++;
	endtask

	task note_request(gdd_pkg::date_req_t w);
		awaited_t e;
		e.req = w;
		e.rsp = predict_day_count(w);
		awaited_q.push_back(e);
	endtask

	task check_result(gdd_pkg::date_rsp_t got);
		awaited_t e;
		if (awaited_q.size() == 0) begin
			report_mismatch($sformatf("result word with no request waiting: days %0d invalid %0b",
				$signed(got.day_difference), got.invalid_date));
		end else begin
			e = awaited_q.pop_front();
			if (got.day_difference !== e.rsp.day_difference)
				report_mismatch($sformatf("%s: day_difference %0d, predicted %0d",
					request_text(e.req), $signed(got.day_difference),
					$signed(e.rsp.day_difference)));
			if (got.invalid_date !== e.rsp.invalid_date)
				report_mismatch($sformatf("%s: invalid_date %b, predicted %b",
					request_text(e.req), got.invalid_date, e.rsp.invalid_date));
		end
	endtask

	function int unsigned pending();
		return awaited_q.size();
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned StallLimit     = 2000;
	localparam int unsigned SettleCycles   = 10;
	localparam int unsigned RandomPerPhase = 300;
	localparam int unsigned DayW           = gdd_pkg::DayW;
	localparam int unsigned MonthW         = gdd_pkg::MonthW;
	localparam int unsigned YearW          = gdd_pkg::YearW;
	localparam int unsigned DefaultMaxYear = gdd_pkg::DefaultMaxYear;

	logic clk;
	logic arst_n;
	int unsigned send_idle_pct = 25;
	int unsigned recv_idle_pct = 74;
	int unsigned quiet_cycles = 0;
	date_diff_scoreboard days_sb;

	gdd_req_if dates_ch();
	gdd_rsp_if result_ch();

	gregorian_date_difference dut (
		.clk(clk),
		.arst_n(arst_n),
		.dates(dates_ch),
		.result(result_ch)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watches both channels; a long stretch with no word moving ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if (dates_ch.valid && dates_ch.ready)
				days_sb.note_request(dates_ch.data);
			if (result_ch.valid && result_ch.ready)
				days_sb.check_result(result_ch.data);
			if ((dates_ch.valid && dates_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= StallLimit) begin
				$display("gregorian_date_difference: mismatch");
				$finish;
			end
		end
	end

	task automatic send_word(gdd_pkg::date_req_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			dates_ch.valid <= 1'b0;
			@(posedge clk);
		end
		dates_ch.valid <= 1'b1;
		dates_ch.data <= w;
		do
			@(posedge clk);
		while (!dates_ch.ready);
	endtask

	task automatic wait_drained();
		dates_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (days_sb.pending() != 0);
	endtask

	function automatic gdd_pkg::date_req_t make_request(int unsigned fd, int unsigned fm,
			int unsigned fy, int unsigned sd, int unsigned sm, int unsigned sy,
			int unsigned incl);
		gdd_pkg::date_req_t w;
		w.first_day    = DayW'(fd);
		w.first_month  = MonthW'(fm);
		w.first_year   = YearW'(fy);
		w.second_day   = DayW'(sd);
		w.second_month = MonthW'(sm);
		w.second_year  = YearW'(sy);
		w.inclusive    = incl[0];
		return w;
	endfunction

	function automatic void pick_valid_date(output logic [DayW-1:0] d,
			output logic [MonthW-1:0] m, output logic [YearW-1:0] y);
		int unsigned yy;
		int unsigned mm;
		int unsigned last;
		case ($urandom_range(9))
			// Around century years, where the leap rule has its exceptions.
			0, 1:    yy = $urandom_range(1, 99) * 100 - 1 + $urandom_range(2);
			2:       yy = $urandom_range(1, 4);
			3:       yy = $urandom_range(DefaultMaxYear - 3, DefaultMaxYear);
			default: yy = $urandom_range(1, DefaultMaxYear);
		endcase
		mm = $urandom_range(1, 12);
		last = days_sb.month_days(mm, yy);
		d = DayW'(($urandom_range(3) == 0) ? last : $urandom_range(1, last));
		m = MonthW'(mm);
		y = YearW'(yy);
	endfunction

	function automatic gdd_pkg::date_req_t random_request();
		gdd_pkg::date_req_t w;
		int unsigned kind;
		kind = $urandom_range(99);
		pick_valid_date(w.first_day, w.first_month, w.first_year);
		if (kind < 65) begin
			pick_valid_date(w.second_day, w.second_month, w.second_year);
		end else if (kind < 78) begin
			w.second_year  = w.first_year;
			w.second_month = MonthW'($urandom_range(1, 12));
			w.second_day   = DayW'($urandom_range(1,
				days_sb.month_days(w.second_month, w.second_year)));
		end else if (kind < 85) begin
			w.second_day   = w.first_day;
			w.second_month = w.first_month;
			w.second_year  = w.first_year;
		end else if (kind < 92) begin
			pick_valid_date(w.second_day, w.second_month, w.second_year);
			case ($urandom_range(5))
				0: w.first_day    = DayW'($urandom);
				1: w.first_month  = MonthW'($urandom);
				2: w.first_year   = YearW'($urandom);
				3: w.second_day   = DayW'($urandom);
				4: w.second_month = MonthW'($urandom);
				default: w.second_year = YearW'($urandom);
			endcase
		end else begin
			w.first_day    = DayW'($urandom);
			w.first_month  = MonthW'($urandom);
			w.first_year   = YearW'($urandom);
			w.second_day   = DayW'($urandom);
			w.second_month = MonthW'($urandom);
			w.second_year  = YearW'($urandom);
		end
		w.inclusive = 1'($urandom_range(1));
		return w;
	endfunction

	initial begin
		days_sb = new();
		arst_n <= 1'b0;
		dates_ch.valid <= 1'b0;
		dates_ch.data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full calendar span both ways, equal dates, leap days and broken fields.
		send_word(make_request(1, 1, 1, 31, 12, 9999, 0));
		send_word(make_request(1, 1, 1, 31, 12, 9999, 1));
		send_word(make_request(31, 12, 9999, 1, 1, 1, 1));
		send_word(make_request(31, 12, 9999, 1, 1, 1, 0));
		send_word(make_request(15, 6, 2024, 15, 6, 2024, 0));
		send_word(make_request(15, 6, 2024, 15, 6, 2024, 1));
		send_word(make_request(28, 2, 2000, 1, 3, 2000, 0));
		send_word(make_request(28, 2, 1900, 1, 3, 1900, 0));
		send_word(make_request(29, 2, 2000, 29, 2, 2400, 1));
		send_word(make_request(29, 2, 1900, 1, 1, 1900, 0));
		send_word(make_request(1, 1, 2023, 29, 2, 2023, 0));
		send_word(make_request(31, 12, 2023, 1, 1, 2024, 1));
		send_word(make_request(1, 3, 2024, 28, 2, 2024, 1));
		send_word(make_request(0, 1, 2000, 1, 1, 2000, 0));
		send_word(make_request(31, 4, 2000, 1, 1, 2000, 0));
		send_word(make_request(31, 1, 2000, 31, 1, 2000, 1));
		send_word(make_request(1, 0, 2000, 1, 1, 2000, 0));
		send_word(make_request(1, 13, 2000, 1, 1, 2000, 1));
		send_word(make_request(1, 1, 2000, 1, 15, 2000, 1));
		send_word(make_request(1, 1, 0, 1, 1, 1, 0));
		send_word(make_request(1, 1, 1, 1, 1, 10000, 1));
		send_word(make_request(31, 15, 16383, 31, 15, 16383, 1));
		send_word(make_request(0, 0, 0, 0, 0, 0, 0));
		send_word(make_request(1, 1, 9999, 31, 12, 9999, 0));
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 25;
					recv_idle_pct = 74;
				end
				1: begin
					send_idle_pct = 74;
					recv_idle_pct = 25;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (RandomPerPhase)
				send_word(random_request());
			wait_drained();
		end

		repeat (SettleCycles) @(posedge clk);
		if (days_sb.mismatch_count == 0)
			$display("gregorian_date_difference: match");
		else
			$display("gregorian_date_difference: mismatch");
		$finish;
	end
endmodule

>>> gregorian_date_difference.f
+incdir+hdl
hdl/gdd_pkg.sv
hdl/gdd_req_if.sv
hdl/gdd_rsp_if.sv
hdl/gdd_day_number.sv
hdl/gregorian_date_difference.sv
tb/tb_top.sv
